@@ sv/ipatp_pkg.sv @@
package ipatp_pkg;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_DOT   = 8'h2e;
	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF    = 8'h66;

	localparam logic [2:0] V4_PARSE     = 3'd0;
	localparam logic [2:0] V4_DOT_PEND  = 3'd1;
	localparam logic [2:0] V4_END_NUL   = 3'd2;
	localparam logic [2:0] V4_END_SLASH = 3'd3;
	localparam logic [2:0] V4_FAIL      = 3'd4;

	localparam logic [2:0] V6_PARSE       = 3'd0;
	localparam logic [2:0] V6_COLON_PEND  = 3'd1;
	localparam logic [2:0] V6_COLON_PEND0 = 3'd2;
	localparam logic [2:0] V6_DCOLON_PEND = 3'd3;
	localparam logic [2:0] V6_END_NUL     = 3'd4;
	localparam logic [2:0] V6_END_SLASH   = 3'd5;
	localparam logic [2:0] V6_FAIL        = 3'd6;

	localparam logic [2:0] P_NONE   = 3'd0;
	localparam logic [2:0] P_SPACE  = 3'd1;
	localparam logic [2:0] P_SIGN   = 3'd2;
	localparam logic [2:0] P_DIGITS = 3'd3;
	localparam logic [2:0] P_DONE   = 3'd6;
	localparam logic [2:0] P_ENDED  = 3'd7;

	localparam logic [8:0]  V4_SAT    = 9'd256;
	localparam logic [8:0]  V4_MAX    = 9'd255;
	localparam logic [16:0] V6_SAT    = 17'd65536;
	localparam logic [16:0] V6_MAX    = 17'd65535;
	localparam logic [7:0]  PFX_SAT   = 8'd255;
	localparam logic [6:0]  PFX_MAX4  = 7'd32;
	localparam logic [6:0]  PFX_MAX6  = 7'd64;
	localparam logic [3:0]  V6_GROUPS = 4'd8;
	localparam logic [2:0]  V4_OCTETS = 3'd4;

	typedef struct packed {
		logic              char_index_zero;
		logic              saw_colon;
		logic              saw_dot;
		logic [0:3][7:0]   v4_octets;
		logic [2:0]        v4_octet_count;
		logic [8:0]        v4_number;
		logic [2:0]        v4_phase;
		logic [3:0]        v6_front_count;
		logic [3:0]        v6_back_count;
		logic [16:0]       v6_number;
		logic              v6_seen;
		logic [2:0]        v6_sub;
		logic [7:0]        prefix_value;
		logic [2:0]        prefix_phase;
	} ctl_t;

	typedef struct packed {
		logic [0:7][15:0] front;
		logic [0:7][15:0] back;
	} grp_t;

	typedef struct packed {
		ctl_t c;
		grp_t g;
	} pst_t;

	typedef struct packed {
		logic        ok;
		logic        is_ipv6;
		logic [63:0] addr_high;
		logic [63:0] addr_low;
		logic [6:0]  prefix_len;
	} res_t;

	localparam ctl_t CTL_RST = '{
		char_index_zero: 1'b1,
		saw_colon:       1'b0,
		saw_dot:         1'b0,
		v4_octets:       32'd0,
		v4_octet_count:  3'd0,
		v4_number:       9'd0,
		v4_phase:        V4_PARSE,
		v6_front_count:  4'd0,
		v6_back_count:   4'd0,
		v6_number:       17'd0,
		v6_seen:         1'b0,
		v6_sub:          V6_PARSE,
		prefix_value:    8'd0,
		prefix_phase:    P_NONE
	};

	function automatic logic is_dec(input logic [7:0] c);
		return (c >= CH_0) && (c <= CH_9);
	endfunction

	function automatic logic [4:0] hex_of(input logic [7:0] c);
		logic [4:0] h;
		h = 5'd16;
		if (is_dec(c)) begin
			h = {1'b0, c[3:0]};
		end else if ((c >= CH_UA && c <= CH_UF) || (c >= CH_LA && c <= CH_LF)) begin
			h = 5'(c[2:0]) + 5'd9;
		end
		return h;
	endfunction

endpackage

@@ sv/ip_address_text_parser.sv @@
// Address text parser for IPv4 and IPv6. One character of the text is taken per
// transaction, with last marking the final one; a single result transaction follows
// each final character. A character is registered on acceptance and stepped through
// both parsers from that register, so the block takes one character every cycle unless
// stalled; a final character's result goes from that register into the output register.
// The only stall is a final character that finds the output register still
// holding an untaken result. No clearing is needed after reset.
module ip_address_text_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  ch,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        ok,
	output logic        is_ipv6,
	output logic [63:0] addr_high,
	output logic [63:0] addr_low,
	output logic [6:0]  prefix_len
);
	import ipatp_pkg::*;

	function automatic ctl_t v4_stop(input ctl_t s, input logic [7:0] c);
		s.v4_phase = (c == CH_NUL) ? V4_END_NUL : ((c == CH_SLASH) ? V4_END_SLASH : V4_FAIL);
		return s;
	endfunction

	function automatic ctl_t v4_parse(input ctl_t s, input logic [7:0] c);
		logic [11:0] n;
		n = {3'd0, s.v4_number} * 12'd10 + {8'd0, c[3:0]};
		if (is_dec(c)) begin
			s.v4_number = (n > 12'(V4_SAT)) ? V4_SAT : n[8:0];
		end else if (s.v4_number > V4_MAX) begin
			s.v4_phase = V4_FAIL;
		end else begin
			if (s.v4_octet_count < V4_OCTETS) begin
				s.v4_octets[s.v4_octet_count[1:0]] = s.v4_number[7:0];
				s.v4_octet_count = s.v4_octet_count + 3'd1;
			end
			if (c == CH_DOT) begin
				s.v4_phase = V4_DOT_PEND;
			end else begin
				s = v4_stop(s, c);
			end
		end
		return s;
	endfunction

	function automatic ctl_t v4_char(input ctl_t s, input logic [7:0] c);
		if (s.v4_phase == V4_PARSE) begin
			s = v4_parse(s, c);
		end else if (s.v4_phase == V4_DOT_PEND) begin
			if (c == CH_DOT) begin
				s.v4_phase = V4_FAIL;
			end else if (s.v4_octet_count >= V4_OCTETS) begin
				s = v4_stop(s, c);
			end else begin
				s.v4_number = 9'd0;
				s.v4_phase = V4_PARSE;
				s = v4_parse(s, c);
			end
		end
		return s;
	endfunction

	function automatic pst_t v6_parse(input pst_t f, input logic [7:0] c, input logic idx0);
		logic [4:0]  h;
		logic [20:0] n;
		logic [4:0]  tot;
		h = hex_of(c);
		n = {f.c.v6_number, 4'd0} + {17'd0, h[3:0]};
		tot = 5'd0;
		if (!h[4]) begin
			f.c.v6_number = (n > 21'(V6_SAT)) ? V6_SAT : n[16:0];
		end else if (f.c.v6_number > V6_MAX) begin
			f.c.v6_sub = V6_FAIL;
		end else begin
			if (!idx0) begin
				if (f.c.v6_seen) begin
					if (f.c.v6_back_count < V6_GROUPS) begin
						f.g.back = {f.g.back[1:7], f.c.v6_number[15:0]};
						f.c.v6_back_count = f.c.v6_back_count + 4'd1;
					end
				end else if (f.c.v6_front_count < V6_GROUPS) begin
					f.g.front[f.c.v6_front_count[2:0]] = f.c.v6_number[15:0];
					f.c.v6_front_count = f.c.v6_front_count + 4'd1;
				end
			end
			tot = {1'b0, f.c.v6_front_count} + {1'b0, f.c.v6_back_count};
			if (c == CH_COLON && tot < {1'b0, V6_GROUPS}) begin
				f.c.v6_sub = idx0 ? V6_COLON_PEND0 : V6_COLON_PEND;
			end else begin
				f.c.v6_sub = (c == CH_NUL) ? V6_END_NUL :
					((c == CH_SLASH) ? V6_END_SLASH : V6_FAIL);
			end
		end
		return f;
	endfunction

	function automatic pst_t v6_char(input pst_t f, input logic [7:0] c, input logic idx0);
		if (f.c.v6_sub == V6_PARSE) begin
			f = v6_parse(f, c, idx0);
		end else if (f.c.v6_sub == V6_COLON_PEND || f.c.v6_sub == V6_COLON_PEND0) begin
			if (c == CH_COLON) begin
				f.c.v6_sub = f.c.v6_seen ? V6_FAIL : V6_DCOLON_PEND;
			end else if (f.c.v6_sub == V6_COLON_PEND0) begin
				f.c.v6_sub = V6_FAIL;
			end else begin
				f.c.v6_number = 17'd0;
				f.c.v6_sub = V6_PARSE;
				f = v6_parse(f, c, 1'b0);
			end
		end else if (f.c.v6_sub == V6_DCOLON_PEND) begin
			if (c == CH_COLON) begin
				f.c.v6_sub = V6_FAIL;
			end else begin
				f.c.v6_number = 17'd0;
				f.c.v6_seen = 1'b1;
				f.c.v6_sub = V6_PARSE;
				f = v6_parse(f, c, 1'b0);
			end
		end
		return f;
	endfunction

	function automatic ctl_t prefix_char(input ctl_t s, input logic [7:0] c);
		logic [11:0] n;
		logic        acc;
		n = {4'd0, s.prefix_value} * 12'd10 + {8'd0, c[3:0]};
		acc = 1'b0;
		case (s.prefix_phase) inside
			P_NONE: begin
				if (c == CH_SLASH) begin
					s.prefix_phase = P_SPACE;
				end
			end
			P_SPACE: begin
				if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
					s.prefix_phase = P_SPACE;
				end else if (c == CH_PLUS) begin
					s.prefix_phase = P_SIGN;
				end else if (is_dec(c)) begin
					acc = 1'b1;
				end else begin
					s.prefix_phase = P_DONE;
				end
			end
			P_SIGN, P_DIGITS: begin
				if (is_dec(c)) begin
					acc = 1'b1;
				end else begin
					s.prefix_phase = P_DONE;
				end
			end
			default: begin
				s.prefix_phase = s.prefix_phase;
			end
		endcase
		if (acc) begin
			s.prefix_value = (n > 12'(PFX_SAT)) ? PFX_SAT : n[7:0];
			s.prefix_phase = P_DIGITS;
		end
		return s;
	endfunction

	function automatic pst_t char_step(input pst_t f, input logic [7:0] c, input logic fin);
		logic idx0;
		idx0 = f.c.char_index_zero;
		if (f.c.prefix_phase != P_ENDED) begin
			if (c == CH_NUL) begin
				f.c = v4_char(f.c, CH_NUL);
				f = v6_char(f, CH_NUL, idx0);
				f.c.prefix_phase = P_ENDED;
			end else begin
				if (c == CH_COLON) begin
					f.c.saw_colon = 1'b1;
				end
				if (c == CH_DOT) begin
					f.c.saw_dot = 1'b1;
				end
				f.c = v4_char(f.c, c);
				f = v6_char(f, c, idx0);
				f.c = prefix_char(f.c, c);
			end
		end
		f.c.char_index_zero = 1'b0;
		if (fin && f.c.prefix_phase != P_ENDED) begin
			f.c = v4_char(f.c, CH_NUL);
			f = v6_char(f, CH_NUL, 1'b0);
			f.c.prefix_phase = P_ENDED;
		end
		return f;
	endfunction

	function automatic logic [6:0] clamp_prefix(input logic slash, input logic [7:0] pv,
		input logic [6:0] pmax);
		logic [6:0] r;
		r = pmax;
		if (slash && pv != 8'd0 && pv <= {1'b0, pmax}) begin
			r = pv[6:0];
		end
		return r;
	endfunction

	function automatic res_t make_result(input pst_t f);
		res_t             r;
		logic [0:7][15:0] g;
		logic [4:0]       tot;
		logic             ends6;
		logic             ends4;
		tot = {1'b0, f.c.v6_front_count} + {1'b0, f.c.v6_back_count};
		for (int j = 0; j < 8; j++) begin
			if (5'(j) + {1'b0, f.c.v6_back_count} >= {1'b0, V6_GROUPS}) begin
				g[j] = f.g.back[j];
			end else if (4'(j) < f.c.v6_front_count) begin
				g[j] = f.g.front[j];
			end else begin
				g[j] = 16'd0;
			end
		end
		ends6 = (f.c.v6_sub == V6_END_NUL) || (f.c.v6_sub == V6_END_SLASH);
		ends4 = (f.c.v4_phase == V4_END_NUL) || (f.c.v4_phase == V4_END_SLASH);
		r.ok = 1'b0;
		r.is_ipv6 = f.c.saw_colon;
		r.addr_high = 64'd0;
		r.addr_low = 64'd0;
		r.prefix_len = 7'd0;
		if (f.c.saw_colon) begin
			if (ends6 && (f.c.v6_seen ? (tot != {1'b0, V6_GROUPS}) :
				(tot == {1'b0, V6_GROUPS}))) begin
				r.ok = 1'b1;
				r.addr_high = g[0:3];
				r.addr_low = g[4:7];
				r.prefix_len = clamp_prefix(f.c.v6_sub == V6_END_SLASH,
					f.c.prefix_value, PFX_MAX6);
			end
		end else if (f.c.saw_dot && ends4) begin
			r.ok = 1'b1;
			r.addr_high = {f.c.v4_octets, 32'd0};
			r.prefix_len = clamp_prefix(f.c.v4_phase == V4_END_SLASH,
				f.c.prefix_value, PFX_MAX4);
		end
		return r;
	endfunction

	logic       valid_s1;
	logic [7:0] ch_s1;
	logic       last_s1;
	ctl_t       ctl_q;
	grp_t       grp_q;
	logic       out_valid_q;
	res_t       res_q;
	logic       step_en;
	pst_t       cur;
	pst_t       nxt;
	res_t       res_d;

	assign step_en = valid_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || step_en;

	always_comb begin
		cur = '{c: ctl_q, g: grp_q};
		nxt = char_step(cur, ch_s1, last_s1);
		res_d = make_result(nxt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ch_s1 <= ch;
			last_s1 <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= CTL_RST;
		end else if (step_en) begin
			ctl_q <= last_s1 ? CTL_RST : nxt.c;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			grp_q <= nxt.g;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step_en && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en && last_s1) begin
			res_q <= res_d;
		end
	end

	assign out_valid = out_valid_q;
	assign ok = res_q.ok;
	assign is_ipv6 = res_q.is_ipv6;
	assign addr_high = res_q.addr_high;
	assign addr_low = res_q.addr_low;
	assign prefix_len = res_q.prefix_len;

	// The parser state returns to its start after every final character.
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && last_s1 |=> ctl_q.char_index_zero && !ctl_q.saw_colon &&
			!ctl_q.saw_dot && ctl_q.prefix_phase == P_NONE)
		else $error("parser state not cleared after final character");

	// A valid address always carries a prefix within its family's range.
	a_prefix_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.ok |-> res_q.prefix_len != 7'd0 &&
			res_q.prefix_len <= (res_q.is_ipv6 ? PFX_MAX6 : PFX_MAX4))
		else $error("prefix length out of range");

	// IPv4 results and rejected text leave the low address half empty.
	a_low_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !(res_q.ok && res_q.is_ipv6) |-> res_q.addr_low == 64'd0)
		else $error("low address half set for non-IPv6 result");

	// Counters never pass their capacity.
	a_counts: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_q.v4_octet_count <= V4_OCTETS && ctl_q.v6_front_count <= V6_GROUPS &&
			ctl_q.v6_back_count <= V6_GROUPS)
		else $error("octet or group count overflow");

endmodule
